// File: hw/rtl/humidity_temp_frame_decoder_assert.svh
// assertion macros for the sensor frame decoder
`ifndef HUMIDITY_TEMP_FRAME_DECODER_ASSERT_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define HTFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("htfd assertion failed");

// next-cycle implication, disabled in reset
`define HTFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("htfd assertion failed");

`endif

// File: hw/rtl/htfd_pkg.sv
// types, constants and crc function for the sensor frame decoder
`timescale 1ns / 1ps

package htfd_pkg;

    localparam int FRAME_BYTES = 7;
    localparam int POS_W       = 3;
    localparam int RAW_W       = 20;
    localparam int CENTI_W     = 16;
    localparam int OFS_W       = 15;
    localparam int CFG_INDEX_W = 1;

    localparam logic [POS_W-1:0] POS_STATUS   = 3'd0;
    localparam logic [POS_W-1:0] POS_HUM_HI   = 3'd1;
    localparam logic [POS_W-1:0] POS_HUM_MID  = 3'd2;
    localparam logic [POS_W-1:0] POS_SPLIT    = 3'd3;
    localparam logic [POS_W-1:0] POS_TEMP_MID = 3'd4;
    localparam logic [POS_W-1:0] POS_TEMP_LO  = 3'd5;
    localparam logic [POS_W-1:0] POS_CRC      = POS_W'(FRAME_BYTES - 1);

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // scale factors, result is product >> 20
    localparam int           SCALE_SHIFT = 20;
    localparam logic [13:0]  HUM_SCALE   = 14'd10000;
    localparam logic [14:0]  TEMP_SCALE  = 15'd20000;
    localparam logic signed [CENTI_W-1:0] TEMP_BIAS = 16'sd5000;

    typedef enum logic [1:0] {
        ERR_OK   = 2'd0,
        ERR_ZERO = 2'd1,
        ERR_CRC  = 2'd2
    } err_code_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_HUM_OFS  = 1'b0,
        REG_TEMP_OFS = 1'b1
    } cfg_index_t;

    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/htfd_ifs.sv
// item channel interfaces for the sensor frame decoder
`timescale 1ns / 1ps

interface htfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

interface htfd_result_if import htfd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [7:0]                status_byte;
    logic [RAW_W-1:0]          humidity_raw;
    logic [RAW_W-1:0]          temperature_raw;
    logic signed [CENTI_W-1:0] humidity_centi;
    logic signed [CENTI_W-1:0] temperature_centi;
    logic [1:0]                error_code;

    modport source (output valid, output status_byte, output humidity_raw,
                    output temperature_raw, output humidity_centi,
                    output temperature_centi, output error_code, input ready);
    modport sink (input valid, input status_byte, input humidity_raw,
                  input temperature_raw, input humidity_centi,
                  input temperature_centi, input error_code, output ready);
endinterface

// File: hw/rtl/humidity_temp_frame_decoder.sv
// sensor reply frame decoder: crc-8 check, raw unpack, scaled hundredths
//
//  channel  | dir | width           | meaning
//  rx       | in  | 8 + 1           | reply byte and start-of-frame flag
//  result   | out | 8+20+20+16+16+2 | status, raw values, hundredths, error
//  cfg      | in  | 1 index, 15 data| humidity and temperature offsets
//
// one byte accepted per cycle while rx.ready is high; crc, zero check and unpack
// run on the byte as it is taken, the seventh byte loads a check stage, scaling
// and offset add fill the output register from it when the output can advance
// rst_n clears frame position, crc and stage valids; no clearing pass
// a stalled result holds its output register, rx stalls only with both stages full
`timescale 1ns / 1ps

module humidity_temp_frame_decoder
    import htfd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    htfd_byte_if.sink              rx,
    htfd_result_if.source          result,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [OFS_W-1:0]       cfg_data
);

    // configuration
    logic signed [OFS_W-1:0] hum_ofs_reg;
    logic signed [OFS_W-1:0] temp_ofs_reg;

    // frame state
    logic [POS_W-1:0] pos_reg;
    logic [7:0]       crc_reg;
    logic             all_zero_reg;
    logic [7:0]       status_reg;
    logic [RAW_W-1:0] hum_acc_reg;
    logic [RAW_W-1:0] temp_acc_reg;

    // check stage
    logic             s1_valid_reg;
    logic [7:0]       s1_status_reg;
    logic [RAW_W-1:0] s1_hum_reg;
    logic [RAW_W-1:0] s1_temp_reg;
    err_code_t        s1_err_reg;
    err_code_t        s1_err_next;

    // output stage
    logic                      out_valid_reg;
    logic [7:0]                out_status_reg;
    logic [RAW_W-1:0]          out_hum_raw_reg;
    logic [RAW_W-1:0]          out_temp_raw_reg;
    logic signed [CENTI_W-1:0] out_hum_reg;
    logic signed [CENTI_W-1:0] out_temp_reg;
    err_code_t                 out_err_reg;
    logic signed [CENTI_W-1:0] out_hum_next;
    logic signed [CENTI_W-1:0] out_temp_next;

    logic             out_adv;
    logic             s1_adv;
    logic             rx_fire;
    logic             last_fire;
    logic [POS_W-1:0] pos_cur;
    logic [7:0]       crc_base;
    logic             zero_base;
    logic             zero_now;
    logic [RAW_W+13:0] hum_prod;
    logic [RAW_W+14:0] temp_prod;
    logic             out_zero_err;
    logic             out_all_zero;
    logic             full_stall;

    assign out_adv  = !out_valid_reg || result.ready;
    assign s1_adv   = !s1_valid_reg || out_adv;
    assign rx.ready = s1_adv;
    assign rx_fire  = rx.valid && rx.ready;

    assign pos_cur   = rx.frame_start ? POS_STATUS : pos_reg;
    assign last_fire = rx_fire && (pos_cur == POS_CRC);
    assign crc_base  = (pos_cur == POS_STATUS) ? CRC_INIT : crc_reg;
    assign zero_base = (pos_cur == POS_STATUS) ? 1'b1 : all_zero_reg;
    assign zero_now  = zero_base && (rx.data_byte == 8'h00);

    always_comb
    begin
        if (zero_now)
        begin
            s1_err_next = ERR_ZERO;
        end
        else if (crc_reg != rx.data_byte)
        begin
            s1_err_next = ERR_CRC;
        end
        else
        begin
            s1_err_next = ERR_OK;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hum_ofs_reg  <= '0;
            temp_ofs_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_HUM_OFS:  hum_ofs_reg  <= cfg_data;
                REG_TEMP_OFS: temp_ofs_reg <= cfg_data;
            endcase
        end
    end

    // frame position, crc and zero tracking
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= POS_STATUS;
            crc_reg      <= CRC_INIT;
            all_zero_reg <= 1'b1;
        end
        else if (rx_fire)
        begin
            all_zero_reg <= zero_now;
            if (pos_cur == POS_CRC)
            begin
                pos_reg <= POS_STATUS;
            end
            else
            begin
                pos_reg <= pos_cur + POS_W'(1);
                crc_reg <= crc_feed(crc_base, rx.data_byte);
            end
        end
    end

    // byte unpack, every field rewritten once per frame
    always_ff @(posedge clk)
    begin
        if (rx_fire)
        begin
            unique case (pos_cur)
                POS_STATUS:   status_reg <= rx.data_byte;
                POS_HUM_HI:   hum_acc_reg[19:12] <= rx.data_byte;
                POS_HUM_MID:  hum_acc_reg[11:4] <= rx.data_byte;
                POS_SPLIT:
                begin
                    hum_acc_reg[3:0]    <= rx.data_byte[7:4];
                    temp_acc_reg[19:16] <= rx.data_byte[3:0];
                end
                POS_TEMP_MID: temp_acc_reg[15:8] <= rx.data_byte;
                POS_TEMP_LO:  temp_acc_reg[7:0] <= rx.data_byte;
                default:      ;
            endcase
        end
    end

    // check stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= last_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (last_fire)
        begin
            s1_status_reg <= status_reg;
            s1_hum_reg    <= hum_acc_reg;
            s1_temp_reg   <= temp_acc_reg;
            s1_err_reg    <= s1_err_next;
        end
    end

    // scaling and offset
    assign hum_prod  = (RAW_W+14)'(s1_hum_reg) * (RAW_W+14)'(HUM_SCALE);
    assign temp_prod = (RAW_W+15)'(s1_temp_reg) * (RAW_W+15)'(TEMP_SCALE);

    assign out_hum_next = $signed({2'b00, hum_prod[SCALE_SHIFT +: 14]})
                        + CENTI_W'(hum_ofs_reg);
    assign out_temp_next = $signed({1'b0, temp_prod[SCALE_SHIFT +: 15]})
                         - TEMP_BIAS + CENTI_W'(temp_ofs_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && s1_valid_reg)
        begin
            out_status_reg   <= s1_status_reg;
            out_hum_raw_reg  <= s1_hum_reg;
            out_temp_raw_reg <= s1_temp_reg;
            out_hum_reg      <= out_hum_next;
            out_temp_reg     <= out_temp_next;
            out_err_reg      <= s1_err_reg;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.status_byte       = out_status_reg;
    assign result.humidity_raw      = out_hum_raw_reg;
    assign result.temperature_raw   = out_temp_raw_reg;
    assign result.humidity_centi    = out_hum_reg;
    assign result.temperature_centi = out_temp_reg;
    assign result.error_code        = out_err_reg;

    assign out_zero_err = out_valid_reg && (out_err_reg == ERR_ZERO);
    assign out_all_zero = (out_status_reg == 8'h00) && (out_hum_raw_reg == '0)
                        && (out_temp_raw_reg == '0);
    assign full_stall   = s1_valid_reg && out_valid_reg && !result.ready;

    `include "humidity_temp_frame_decoder_assert.svh"

    `HTFD_ASSERT_NEXT(a_last_loads, clk, rst_n, last_fire, s1_valid_reg)
    `HTFD_ASSERT_NOW(a_pos_range, clk, rst_n, 1'b1, pos_reg <= POS_CRC)
    `HTFD_ASSERT_NOW(a_zero_fields, clk, rst_n, out_zero_err, out_all_zero)
    `HTFD_ASSERT_NOW(a_stall_cause, clk, rst_n, !rx.ready, full_stall)

endmodule

// File: verif/humidity_temp_frame_decoder_tb.sv
// self-checking testbench for the sensor reply frame decoder
`timescale 1ns / 1ps

module humidity_temp_frame_decoder_tb;
    import htfd_pkg::*;

    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 330;
    localparam int SETTLE_CYCLES   = 4;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 5000;

    typedef struct packed {
        logic [7:0]                status;
        logic [RAW_W-1:0]          hum_raw;
        logic [RAW_W-1:0]          temp_raw;
        logic signed [CENTI_W-1:0] hum_centi;
        logic signed [CENTI_W-1:0] temp_centi;
        err_code_t                 err;
    } reading_t;

    typedef struct {
        logic [7:0] b;
        logic       start;
        bit         fix_crc;
        bit         typed;
        reading_t   want;
    } byte_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [OFS_W-1:0]       cfg_data;

    htfd_byte_if   rx_if ();
    htfd_result_if result_if ();

    humidity_temp_frame_decoder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx_if),
        .result    (result_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // decoder state as predicted
    logic [POS_W-1:0] frame_pos   = POS_STATUS;
    logic [7:0]       crc_acc     = CRC_INIT;
    bit               zeros_only  = 1'b1;
    logic [7:0]       status_q    = 8'h00;
    logic [RAW_W-1:0] hum_acc     = '0;
    logic [RAW_W-1:0] temp_acc    = '0;
    int               hum_ofs     = 0;
    int               temp_ofs    = 0;

    reading_t  pending_readings[$];
    byte_row_t directed_rows[$];

    int  errors = 0;
    int  bytes_sent = 0;
    int  readings_checked = 0;
    int  err_seen[3] = '{0, 0, 0};
    int  phase_num = 0;
    bit  calm = 1'b0;
    bit  gap_mode = 1'b1;
    int  idle_cycles = 0;
    int  phase_start;
    int  hum_set;
    int  temp_set;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        repeat (8)
        begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic signed [CENTI_W-1:0] sat16(input int v);
        if (v > 32767)
        begin
            return 16'sh7FFF;
        end
        if (v < -32768)
        begin
            return 16'sh8000;
        end
        return v[CENTI_W-1:0];
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, input logic start,
                                       output reading_t r);
        logic [POS_W-1:0] pos;
        int               hum;
        int               tmp;
        pos = start ? POS_STATUS : frame_pos;
        r = '0;
        if (pos == POS_STATUS)
        begin
            crc_acc    = CRC_INIT;
            zeros_only = 1'b1;
            status_q   = b;
        end
        zeros_only = zeros_only && (b == 8'h00);
        if (pos != POS_CRC)
        begin
            crc_acc = crc8_step(crc_acc, b);
            case (pos)
                POS_HUM_HI:   hum_acc = {b, 12'h000};
                POS_HUM_MID:  hum_acc = {hum_acc[19:12], b, 4'h0};
                POS_SPLIT:
                begin
                    hum_acc  = {hum_acc[19:4], b[7:4]};
                    temp_acc = {b[3:0], 16'h0000};
                end
                POS_TEMP_MID: temp_acc = {temp_acc[19:16], b, 8'h00};
                POS_TEMP_LO:  temp_acc = {temp_acc[19:8], b};
                default:      ;
            endcase
            frame_pos = pos + POS_W'(1);
            return 1'b0;
        end
        if (zeros_only)
        begin
            r.err = ERR_ZERO;
        end
        else if (crc_acc != b)
        begin
            r.err = ERR_CRC;
        end
        else
        begin
            r.err = ERR_OK;
        end
        hum = int'((64'(hum_acc) * 64'd10000) >> SCALE_SHIFT) + hum_ofs;
        tmp = int'((64'(temp_acc) * 64'd20000) >> SCALE_SHIFT) - 5000 + temp_ofs;
        r.status     = status_q;
        r.hum_raw    = hum_acc;
        r.temp_raw   = temp_acc;
        r.hum_centi  = sat16(hum);
        r.temp_centi = sat16(tmp);
        frame_pos = POS_STATUS;
        return 1'b1;
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic add_row(input logic [7:0] b, input logic start, input bit fix_crc = 1'b0,
                           input bit typed = 1'b0, input reading_t want = '0);
        byte_row_t row;
        row.b       = b;
        row.start   = start;
        row.fix_crc = fix_crc;
        row.typed   = typed;
        row.want    = want;
        directed_rows.push_back(row);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic start, input bit typed,
                             input reading_t want);
        reading_t r;
        bit       got;
        rx_if.valid       <= 1'b1;
        rx_if.data_byte   <= b;
        rx_if.frame_start <= start;
        @(posedge clk);
        while (rx_if.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        got = decode_byte(b, start, r);
        if (got)
        begin
            pending_readings.push_back(typed ? want : r);
        end
        bytes_sent++;
        if (bytes_sent % 64 == 0)
        begin
            gap_mode = 1'($urandom_range(0, 1));
        end
        if (!calm && gap_mode && $urandom_range(0, 3) == 0)
        begin
            rx_if.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // mostly whole frames; some truncated, bad-crc, all-zero and stray bytes
    task automatic send_frame();
        int         kind;
        int         len;
        logic [7:0] b;
        logic       st;
        kind = $urandom_range(0, 99);
        if (kind < 10)
        begin
            send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
            return;
        end
        st  = (frame_pos != POS_STATUS) ? 1'b1 : 1'($urandom_range(0, 1));
        len = (kind < 20) ? $urandom_range(1, FRAME_BYTES - 1) : FRAME_BYTES;
        for (int i = 0; i < len; i++)
        begin
            if (kind < 25 && kind >= 20)
            begin
                b = 8'h00;
            end
            else if (i == FRAME_BYTES - 1)
            begin
                b = (kind < 85) ? crc_acc : rand_byte();
            end
            else
            begin
                b = rand_byte();
            end
            send_byte(b, (i == 0) ? st : 1'b0, 1'b0, '0);
        end
    endtask

    task automatic drain();
        while (pending_readings.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_offsets(input int h, input int t);
        cfg_we    <= 1'b1;
        cfg_index <= REG_HUM_OFS;
        cfg_data  <= OFS_W'(h);
        @(posedge clk);
        cfg_index <= REG_TEMP_OFS;
        cfg_data  <= OFS_W'(t);
        @(posedge clk);
        cfg_we    <= 1'b0;
        hum_ofs  = h;
        temp_ofs = t;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            if (pending_readings.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual status %0h err %0d",
                         $time, result_if.status_byte, result_if.error_code);
                errors++;
            end
            else
            begin
                want = pending_readings.pop_front();
                check_field("status_byte", int'(want.status),
                            int'(result_if.status_byte));
                check_field("humidity_raw", int'(want.hum_raw),
                            int'(result_if.humidity_raw));
                check_field("temperature_raw", int'(want.temp_raw),
                            int'(result_if.temperature_raw));
                check_field("humidity_centi", int'(want.hum_centi),
                            int'(result_if.humidity_centi));
                check_field("temperature_centi", int'(want.temp_centi),
                            int'(result_if.temperature_centi));
                check_field("error_code", int'(want.err), int'(result_if.error_code));
                readings_checked++;
                err_seen[int'(want.err)]++;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((rx_if.valid && rx_if.ready) || (result_if.valid && result_if.ready) || cfg_we)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d items outstanding", $time,
                     pending_readings.size());
            $display("Some tests failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver side
    initial
    begin
        int  cycles;
        bit  held_off;
        bit  stall_mode;
        cycles     = 0;
        held_off   = 1'b0;
        stall_mode = 1'b0;
        result_if.ready = 1'b0;
        @(posedge clk);
        forever
        begin
            cycles++;
            if (cycles % 64 == 0)
            begin
                stall_mode = 1'($urandom_range(0, 1));
            end
            if (!held_off && phase_num == 2)
            begin
                // long hold-off so the decoder backs up onto its input
                result_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                held_off = 1'b1;
            end
            else if (!calm && stall_mode && $urandom_range(0, 3) == 0)
            begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
            end
            else
            begin
                result_if.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // sender side and run control
    initial
    begin
        rst_n             = 1'b0;
        rx_if.valid       = 1'b0;
        rx_if.data_byte   = 8'h00;
        rx_if.frame_start = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = REG_HUM_OFS;
        cfg_data          = '0;

        // all-zero frame: zero check wins over the bad crc
        add_row(8'h00, 1'b1);
        repeat (5) add_row(8'h00, 1'b0);
        add_row(8'h00, 1'b0, 1'b0, 1'b1,
                '{8'h00, 20'h00000, 20'h00000, 16'sd0, -16'sd5000, ERR_ZERO});
        // all-ones frame, top of both scales, crc mismatch
        add_row(8'hFF, 1'b1);
        repeat (5) add_row(8'hFF, 1'b0);
        add_row(8'hFF, 1'b0, 1'b0, 1'b1,
                '{8'hFF, 20'hFFFFF, 20'hFFFFF, 16'sd9999, 16'sd14999, ERR_CRC});
        // unflagged byte after a frame, then restart in mid frame
        add_row(8'h55, 1'b0);
        add_row(8'h66, 1'b0);
        add_row(8'h18, 1'b1);
        add_row(8'h80, 1'b0);
        add_row(8'h00, 1'b0);
        add_row(8'h5A, 1'b0);
        add_row(8'h12, 1'b0);
        add_row(8'h34, 1'b0);
        add_row(8'h00, 1'b0, 1'b1);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_byte(directed_rows[i].fix_crc ? crc_acc : directed_rows[i].b,
                      directed_rows[i].start, directed_rows[i].typed, directed_rows[i].want);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase > 0)
            begin
                rx_if.valid <= 1'b0;
                drain();
                case (phase)
                    1:       begin hum_set = -10000; temp_set = 10000;  end
                    2:       begin hum_set = 10000;  temp_set = -10000; end
                    3:       begin hum_set = -16384; temp_set = 16383;  end
                    4:       begin hum_set = 16383;  temp_set = -16384; end
                    default:
                    begin
                        hum_set  = $urandom_range(0, 32767) - 16384;
                        temp_set = $urandom_range(0, 32767) - 16384;
                    end
                endcase
                write_offsets(hum_set, temp_set);
            end
            phase_num   = phase;
            calm        = (phase == NUM_PHASES - 1);
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < ITEMS_PER_PHASE)
            begin
                send_frame();
            end
        end

        rx_if.valid <= 1'b0;
        drain();

        $display("sent %0d bytes over %0d offset settings, %0d readings checked",
                 bytes_sent, NUM_PHASES, readings_checked);
        $display("readings by code: ok %0d, all-zero %0d, crc mismatch %0d",
                 err_seen[ERR_OK], err_seen[ERR_ZERO], err_seen[ERR_CRC]);
        if (errors == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/htfd_pkg.sv
hw/rtl/htfd_ifs.sv
hw/rtl/humidity_temp_frame_decoder.sv
verif/humidity_temp_frame_decoder_tb.sv
